### rtl/ssi_pkg.sv
// ----------------------------------------------------------------------------
// ssi_pkg
// Types, codes and sizes shared by the searchable stack and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package ssi_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int COUNT_W    = 5;

  localparam logic [2:0] CMD_PUSH      = 3'd0;
  localparam logic [2:0] CMD_POP       = 3'd1;
  localparam logic [2:0] CMD_PEEK      = 3'd2;
  localparam logic [2:0] CMD_INS_BELOW = 3'd3;
  localparam logic [2:0] CMD_INS_ABOVE = 3'd4;

  localparam logic [1:0] STAT_DONE     = 2'd0;
  localparam logic [1:0] STAT_EMPTY    = 2'd1;
  localparam logic [1:0] STAT_FULL     = 2'd2;
  localparam logic [1:0] STAT_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [2:0]            cmd;
    logic [DATA_WIDTH-1:0] value;
    logic [DATA_WIDTH-1:0] target;
  } in_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] read_value;
    logic                  ok;
    logic [1:0]            status;
    logic [COUNT_W-1:0]    count;
    logic                  empty_res;
  } out_t;

  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_PUSH = 2'd1,
    OP_POP  = 2'd2,
    OP_INS  = 2'd3
  } cell_op_t;

  typedef struct packed {
    logic     capture;
    logic     scan;
    cell_op_t op;
    logic     below;
  } cell_ctl_t;

endpackage

`default_nettype wire

### rtl/searchable_stack_insert.sv
// ----------------------------------------------------------------------------
// searchable_stack_insert
// Bounded stack, top at slot 0, built as a row of shifting cells. Push, pop,
// peek, and insert next to the first entry from the top matching a target.
//
//   channel   ports                  transfer
//   --------  ---------------------  ------------------------------
//   command   start, busy, item      start high and busy low
//   result    done, result           done high, one cycle, no stall
//
// Push, pop, peek and any rejected command: result in the cycle after the
// transfer; a new command may be taken in that same cycle.
// Accepted insert: busy while the match flag walks one cell per cycle down
// the row until it reaches the fill mark, then the result.
// Reset empties the stack at once; entries are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module searchable_stack_insert #(
  parameter int DEPTH = ssi_pkg::DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire ssi_pkg::in_t  item,
  output logic               done,
  output ssi_pkg::out_t      result
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int DW = ssi_pkg::DATA_WIDTH;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t             state, state_next;
  logic [CW-1:0]      fill, fill_next;
  logic [CW-1:0]      k, k_next;
  logic [DW-1:0]      value_q, value_next;
  logic               below_q, below_next;
  logic               done_next;
  ssi_pkg::out_t      res_next;
  ssi_pkg::cell_ctl_t ctl;
  logic [DW-1:0]      ins_value;
  logic               full;

  logic [DEPTH-1:0][DW-1:0] entry_vec;
  logic [DEPTH-1:0]         seen_vec;
  logic [DEPTH-1:0]         match_vec;

  assign busy      = (state == ST_SCAN);
  assign full      = (fill == CW'(DEPTH));
  assign ins_value = (state == ST_IDLE) ? item.value : value_q;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DW-1:0] up_entry;
    logic [DW-1:0] dn_entry;
    logic          up_seen;
    logic          up_match;

    if (i == 0) begin : g_top
      assign up_entry = ins_value;
      assign up_seen  = 1'b0;
      assign up_match = 1'b0;
    end else begin : g_mid
      assign up_entry = entry_vec[i-1];
      assign up_seen  = seen_vec[i-1];
      assign up_match = match_vec[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign dn_entry = entry_vec[i];
    end else begin : g_inner
      assign dn_entry = entry_vec[i+1];
    end

    ssi_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .valid    (fill > CW'(i)),
      .target   (item.target),
      .value    (ins_value),
      .up_entry (up_entry),
      .up_seen  (up_seen),
      .up_match (up_match),
      .dn_entry (dn_entry),
      .entry    (entry_vec[i]),
      .seen     (seen_vec[i]),
      .match    (match_vec[i])
    );
  end

  always_comb begin
    state_next  = state;
    fill_next   = fill;
    k_next      = k;
    value_next  = value_q;
    below_next  = below_q;
    done_next   = 1'b0;
    ctl.capture = 1'b0;
    ctl.scan    = 1'b0;
    ctl.op      = ssi_pkg::OP_HOLD;
    ctl.below   = below_q;
    res_next    = '0;

    case (state)
      ST_IDLE: begin
        if (start) begin
          done_next = 1'b1;
          case (item.cmd)
            ssi_pkg::CMD_PUSH: begin
              if (full) begin
                res_next.status = ssi_pkg::STAT_FULL;
              end else begin
                ctl.op      = ssi_pkg::OP_PUSH;
                fill_next   = fill + CW'(1);
                res_next.ok = 1'b1;
              end
            end
            ssi_pkg::CMD_POP, ssi_pkg::CMD_PEEK: begin
              if (fill == '0) begin
                res_next.status = ssi_pkg::STAT_EMPTY;
              end else begin
                res_next.read_value = entry_vec[0];
                res_next.ok         = 1'b1;
                if (item.cmd == ssi_pkg::CMD_POP) begin
                  ctl.op    = ssi_pkg::OP_POP;
                  fill_next = fill - CW'(1);
                end
              end
            end
            ssi_pkg::CMD_INS_BELOW, ssi_pkg::CMD_INS_ABOVE: begin
              if (full) begin
                res_next.status = ssi_pkg::STAT_FULL;
              end else begin
                done_next   = 1'b0;
                ctl.capture = 1'b1;
                state_next  = ST_SCAN;
                k_next      = '0;
                value_next  = item.value;
                below_next  = (item.cmd == ssi_pkg::CMD_INS_BELOW);
              end
            end
            default: begin
              res_next.status = ssi_pkg::STAT_DONE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (k == fill) begin
          done_next  = 1'b1;
          state_next = ST_IDLE;
          if (seen_vec[fill[AW-1:0]]) begin
            ctl.op      = ssi_pkg::OP_INS;
            fill_next   = fill + CW'(1);
            res_next.ok = 1'b1;
          end else begin
            res_next.status = ssi_pkg::STAT_NOTFOUND;
          end
        end else begin
          ctl.scan = 1'b1;
          k_next   = k + CW'(1);
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    res_next.count     = ssi_pkg::COUNT_W'(fill_next);
    res_next.empty_res = (fill_next == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fill  <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    k       <= k_next;
    value_q <= value_next;
    below_q <= below_next;
    result  <= res_next;
  end

endmodule

`default_nettype wire

### rtl/ssi_cell.sv
// ----------------------------------------------------------------------------
// ssi_cell
// One stack slot: holds an entry, its compare flag and the match-seen flag
// passed down from the slot above; shifts with its neighbours.
// ----------------------------------------------------------------------------
`default_nettype none

module ssi_cell (
  input  wire logic                          clk,
  input  wire ssi_pkg::cell_ctl_t            ctl,
  input  wire logic                          valid,
  input  wire logic [ssi_pkg::DATA_WIDTH-1:0] target,
  input  wire logic [ssi_pkg::DATA_WIDTH-1:0] value,
  input  wire logic [ssi_pkg::DATA_WIDTH-1:0] up_entry,
  input  wire logic                          up_seen,
  input  wire logic                          up_match,
  input  wire logic [ssi_pkg::DATA_WIDTH-1:0] dn_entry,
  output logic      [ssi_pkg::DATA_WIDTH-1:0] entry,
  output logic                               seen,
  output logic                               match
);

  logic mine_pos;
  logic up_pos;
  logic mine_load;

  // at or below the insert position
  assign mine_pos  = ctl.below ? seen : (seen | match);
  assign up_pos    = ctl.below ? up_seen : (up_seen | up_match);
  assign mine_load = mine_pos & ~up_pos;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      match <= valid && (entry == target);
      seen  <= 1'b0;
    end else if (ctl.scan) begin
      seen <= up_seen | up_match;
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      ssi_pkg::OP_HOLD: begin
        entry <= entry;
      end
      ssi_pkg::OP_PUSH: begin
        entry <= up_entry;
      end
      ssi_pkg::OP_POP: begin
        entry <= dn_entry;
      end
      ssi_pkg::OP_INS: begin
        if (mine_load) begin
          entry <= value;
        end else if (mine_pos) begin
          entry <= up_entry;
        end
      end
      default: begin
        entry <= entry;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/ssi_checker.sv
// ----------------------------------------------------------------------------
// ssi_checker
// Port-level checks on the searchable stack, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ssi_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          start,
  input wire logic          busy,
  input wire ssi_pkg::in_t  item,
  input wire logic          done,
  input wire ssi_pkg::out_t result
);

  a_ok_done: assert property (@(posedge clk) disable iff (rst)
    (done && result.ok) |-> (result.status == ssi_pkg::STAT_DONE))
    else $error("successful result with failure status");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.empty_res == (result.count == '0)))
    else $error("empty flag disagrees with count");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> ($past(start) && (($past(item.cmd) == ssi_pkg::CMD_INS_BELOW) ||
                                      ($past(item.cmd) == ssi_pkg::CMD_INS_ABOVE))))
    else $error("busy without an insert transfer");

  a_empty_read: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == ssi_pkg::STAT_EMPTY)) |->
      ((result.count == '0) && (result.read_value == '0)))
    else $error("empty failure with data or entries");

endmodule

bind searchable_stack_insert ssi_checker u_ssi_checker (.*);

`default_nettype wire

### tb/sv/tb_searchable_stack_insert.sv
// ----------------------------------------------------------------------------
// tb_searchable_stack_insert
// Self-checking bench for the searchable stack. A shadow copy of the stack
// is stepped on every accepted command to give the expected answer. Each
// answer from the block is compared field by field with the oldest one
// outstanding. A short set of hand-picked commands comes first, then
// fill-to-full and drain passes, then weighted random traffic. The sender
// works in bursts with random gaps between them, but none in the last pass.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_searchable_stack_insert;

  localparam logic [2:0] CMD_RSVD5 = 3'd5;
  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;

  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE       = ssi_pkg::DEPTH + 4;

  logic          clk   = 1'b0;
  logic          rst   = 1'b1;
  logic          start = 1'b0;
  ssi_pkg::in_t  item  = '0;
  logic          busy;
  logic          done;
  ssi_pkg::out_t result;

  logic [ssi_pkg::DATA_WIDTH-1:0] shadow_words [ssi_pkg::DEPTH];
  int            shadow_fill = 0;
  ssi_pkg::out_t pending_answers [$];

  int errors     = 0;
  int cycles     = 0;
  int burst_left = 0;
  bit gaps_on    = 1'b1;
  int peak_fill  = 0;
  int cmd_seen  [8];
  int stat_seen [4];

  searchable_stack_insert DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // open a slot at pos, shift everything below it down one place
  function automatic void insert_word(input int pos,
                                      input logic [ssi_pkg::DATA_WIDTH-1:0] w);
    for (int i = shadow_fill; i > pos; i--) shadow_words[i] = shadow_words[i-1];
    shadow_words[pos] = w;
    shadow_fill++;
  endfunction

  function automatic ssi_pkg::out_t stack_answer(input ssi_pkg::in_t x);
    ssi_pkg::out_t r;
    int            pos;
    r        = '0;
    r.status = ssi_pkg::STAT_DONE;
    case (x.cmd)
      ssi_pkg::CMD_PUSH: begin
        if (shadow_fill >= ssi_pkg::DEPTH) begin
          r.status = ssi_pkg::STAT_FULL;
        end else begin
          insert_word(0, x.value);
          r.ok = 1'b1;
        end
      end
      ssi_pkg::CMD_POP, ssi_pkg::CMD_PEEK: begin
        if (shadow_fill == 0) begin
          r.status = ssi_pkg::STAT_EMPTY;
        end else begin
          r.read_value = shadow_words[0];
          r.ok         = 1'b1;
          if (x.cmd == ssi_pkg::CMD_POP) begin
            for (int i = 0; i + 1 < shadow_fill; i++)
              shadow_words[i] = shadow_words[i+1];
            shadow_fill--;
          end
        end
      end
      ssi_pkg::CMD_INS_BELOW, ssi_pkg::CMD_INS_ABOVE: begin
        if (shadow_fill >= ssi_pkg::DEPTH) begin
          r.status = ssi_pkg::STAT_FULL;
        end else begin
          pos = shadow_fill;
          for (int i = shadow_fill - 1; i >= 0; i--)
            if (shadow_words[i] == x.target) pos = i;
          if (pos >= shadow_fill) begin
            r.status = ssi_pkg::STAT_NOTFOUND;
          end else begin
            insert_word((x.cmd == ssi_pkg::CMD_INS_BELOW) ? pos + 1 : pos, x.value);
            r.ok = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.count     = ssi_pkg::COUNT_W'(shadow_fill);
    r.empty_res = (shadow_fill == 0);
    return r;
  endfunction

  function automatic ssi_pkg::in_t mk(input logic [2:0] c,
                                      input logic [ssi_pkg::DATA_WIDTH-1:0] v,
                                      input logic [ssi_pkg::DATA_WIDTH-1:0] t);
    ssi_pkg::in_t x;
    x.cmd    = c;
    x.value  = v;
    x.target = t;
    return x;
  endfunction

  // small pool values give duplicates, so first-match-from-top gets exercised
  function automatic logic [ssi_pkg::DATA_WIDTH-1:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return ssi_pkg::DATA_WIDTH'($urandom_range(0, 5));
      default: return ssi_pkg::DATA_WIDTH'($urandom());
    endcase
  endfunction

  function automatic logic [ssi_pkg::DATA_WIDTH-1:0] pick_target(input int hit_pct);
    if (shadow_fill > 0 && $urandom_range(0, 99) < hit_pct)
      return shadow_words[$urandom_range(0, shadow_fill - 1)];
    return rand_word();
  endfunction

  function automatic ssi_pkg::in_t random_cmd(input int w_push, input int w_pop,
                                              input int w_peek, input int w_ins,
                                              input int w_odd);
    int         roll;
    logic [2:0] c;
    roll = $urandom_range(0, w_push + w_pop + w_peek + w_ins + w_odd - 1);
    if (roll < w_push)                              c = ssi_pkg::CMD_PUSH;
    else if (roll < w_push + w_pop)                 c = ssi_pkg::CMD_POP;
    else if (roll < w_push + w_pop + w_peek)        c = ssi_pkg::CMD_PEEK;
    else if (roll < w_push + w_pop + w_peek + w_ins)
      c = $urandom_range(0, 1) ? ssi_pkg::CMD_INS_BELOW : ssi_pkg::CMD_INS_ABOVE;
    else c = 3'($urandom_range(CMD_RSVD5, CMD_RSVD7));
    return mk(c, rand_word(), pick_target(80));
  endfunction

  // one command transfer; expectation is queued at the accepting edge
  task automatic send_cmd(input ssi_pkg::in_t x);
    int gap;
    if (burst_left == 0) begin
      if (gaps_on) begin
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    start <= 1'b1;
    item  <= x;
    do @(posedge clk); while (busy);
    cmd_seen[x.cmd]++;
    pending_answers.push_back(stack_answer(x));
    if (shadow_fill > peak_fill) peak_fill = shadow_fill;
  endtask

  task automatic wait_all_answers();
    start <= 1'b0;
    burst_left = 0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    ssi_pkg::out_t e;
    if (!rst && done) begin
      if (pending_answers.size() == 0) begin
        $error("unexpected result: no command outstanding");
        errors++;
      end else begin
        e = pending_answers.pop_front();
        stat_seen[result.status]++;
        if (result.read_value !== e.read_value) begin
          $error("read_value: expected %h, actual %h", e.read_value, result.read_value);
          errors++;
        end
        if (result.ok !== e.ok) begin
          $error("ok: expected %b, actual %b", e.ok, result.ok);
          errors++;
        end
        if (result.status !== e.status) begin
          $error("status: expected %0d, actual %0d", e.status, result.status);
          errors++;
        end
        if (result.count !== e.count) begin
          $error("count: expected %0d, actual %0d", e.count, result.count);
          errors++;
        end
        if (result.empty_res !== e.empty_res) begin
          $error("empty_res: expected %b, actual %b", e.empty_res, result.empty_res);
          errors++;
        end
      end
    end
  end

  task automatic test_directed_cases();
    send_cmd(mk(ssi_pkg::CMD_POP,       '0, '0));
    send_cmd(mk(ssi_pkg::CMD_PEEK,      '1, '1));
    send_cmd(mk(ssi_pkg::CMD_INS_BELOW, 32'd9, 32'd0));
    send_cmd(mk(ssi_pkg::CMD_INS_ABOVE, 32'd9, 32'd0));
    send_cmd(mk(ssi_pkg::CMD_PUSH,      '0, '1));
    send_cmd(mk(ssi_pkg::CMD_PUSH,      '1, '0));
    send_cmd(mk(ssi_pkg::CMD_PEEK,      '0, '0));
    send_cmd(mk(ssi_pkg::CMD_INS_BELOW, 32'd1, '1));
    send_cmd(mk(ssi_pkg::CMD_INS_ABOVE, 32'd2, '0));
    send_cmd(mk(ssi_pkg::CMD_INS_BELOW, 32'd7, 32'h0000_0055));
    send_cmd(mk(ssi_pkg::CMD_PUSH,      32'd1, 32'd0));
    send_cmd(mk(ssi_pkg::CMD_INS_ABOVE, 32'd3, 32'd1));
    send_cmd(mk(ssi_pkg::CMD_INS_BELOW, 32'd4, 32'd0));
    send_cmd(mk(CMD_RSVD5,              '1, '1));
    send_cmd(mk(CMD_RSVD6,              32'hA5A5_A5A5, 32'd1));
    send_cmd(mk(CMD_RSVD7,              '1, '0));
    send_cmd(mk(ssi_pkg::CMD_POP,       '1, '1));
    send_cmd(mk(ssi_pkg::CMD_PEEK,      '0, '0));
    send_cmd(mk(ssi_pkg::CMD_PUSH,      32'hAAAA_AAAA, 32'h5555_5555));
    send_cmd(mk(ssi_pkg::CMD_INS_ABOVE, 32'h5555_5555, 32'hAAAA_AAAA));
    send_cmd(mk(ssi_pkg::CMD_INS_BELOW, '1, 32'd4));
    wait_all_answers();
  endtask

  task automatic test_fill_and_empty();
    int guard;
    repeat (2) begin
      guard = 0;
      while (shadow_fill < ssi_pkg::DEPTH && guard < 64) begin
        send_cmd(random_cmd(3, 0, 1, 3, 0));
        guard++;
      end
      send_cmd(mk(ssi_pkg::CMD_PUSH, rand_word(), rand_word()));
      send_cmd(mk(ssi_pkg::CMD_INS_BELOW, rand_word(), pick_target(100)));
      send_cmd(mk(ssi_pkg::CMD_INS_ABOVE, rand_word(), 32'hDEAD_BEEF));
      send_cmd(mk(ssi_pkg::CMD_PEEK, rand_word(), rand_word()));
      while (shadow_fill > 0 && guard < 128) begin
        send_cmd(mk(ssi_pkg::CMD_POP, rand_word(), rand_word()));
        guard++;
      end
      send_cmd(mk(ssi_pkg::CMD_POP, rand_word(), rand_word()));
      send_cmd(mk(ssi_pkg::CMD_PEEK, rand_word(), rand_word()));
      send_cmd(mk(ssi_pkg::CMD_INS_ABOVE, rand_word(), rand_word()));
      wait_all_answers();
    end
  endtask

  task automatic test_random_traffic(input int n, input int w_push, input int w_pop,
                                     input int w_peek, input int w_ins, input int w_odd);
    repeat (n) send_cmd(random_cmd(w_push, w_pop, w_peek, w_ins, w_odd));
    wait_all_answers();
  endtask

  initial begin
    foreach (shadow_words[i]) shadow_words[i] = '0;
    foreach (cmd_seen[i]) cmd_seen[i] = 0;
    foreach (stat_seen[i]) stat_seen[i] = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_fill_and_empty();
    test_random_traffic(250, 3, 2, 1, 3, 1);
    test_random_traffic(150, 6, 1, 1, 4, 0);
    test_random_traffic(100, 1, 5, 2, 2, 0);
    gaps_on = 1'b0;
    test_random_traffic(150, 2, 2, 1, 5, 0);

    repeat (SETTLE) @(posedge clk);
    $display("Commands: push %0d, pop %0d, peek %0d, insert below %0d, above %0d, other %0d",
             cmd_seen[ssi_pkg::CMD_PUSH], cmd_seen[ssi_pkg::CMD_POP],
             cmd_seen[ssi_pkg::CMD_PEEK], cmd_seen[ssi_pkg::CMD_INS_BELOW],
             cmd_seen[ssi_pkg::CMD_INS_ABOVE],
             cmd_seen[CMD_RSVD5] + cmd_seen[CMD_RSVD6] + cmd_seen[CMD_RSVD7]);
    $display("Answers: done %0d, empty %0d, full %0d, not found %0d; peak fill %0d of %0d",
             stat_seen[ssi_pkg::STAT_DONE], stat_seen[ssi_pkg::STAT_EMPTY],
             stat_seen[ssi_pkg::STAT_FULL], stat_seen[ssi_pkg::STAT_NOTFOUND],
             peak_fill, ssi_pkg::DEPTH);
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
